// File: hw/rtl/escaped_utf8_text_decoder_core_defines.svh
// Assertion macros for the escaped UTF-8 text decoder.
`ifndef ESCAPED_UTF8_TEXT_DECODER_CORE_DEFINES_SVH
`define ESCAPED_UTF8_TEXT_DECODER_CORE_DEFINES_SVH

// Checked outside reset only.
`define ETUD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ETUD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/etud_pkg.sv
// Types, character codes and helpers for the escaped UTF-8 text decoder.
package etud_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        was_escaped;
    logic        non_ascii;
    logic        decode_error;
  } out_req_t;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_U2       = 9'b000000010,
    PH_U3       = 9'b000000100,
    PH_U4       = 9'b000001000,
    PH_ESC      = 9'b000010000,
    PH_HEX      = 9'b000100000,
    PH_PAIR_BS  = 9'b001000000,
    PH_PAIR_U   = 9'b010000000,
    PH_PAIR_HEX = 9'b100000000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [20:0] partial;
    logic [2:0]  remaining;
    logic [9:0]  high_surr;
  } dec_state_t;

  typedef struct packed {
    logic     valid;
    out_req_t req;
  } dec_result_t;

  localparam dec_state_t IdleState = '{
    phase:     PH_IDLE,
    partial:   21'd0,
    remaining: 3'd0,
    high_surr: 10'd0
  };

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [20:0] MaxCodePoint = 21'h10FFFF;

  // {ok, value} for one ASCII hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/etud_decode.sv
// Next-state and result logic for one text byte.
module etud_decode (
  input  etud_pkg::dec_state_t  cur_i,
  input  etud_pkg::in_req_t     req_i,
  input  logic                  esc_en_i,
  output etud_pkg::dec_state_t  nxt_o,
  output etud_pkg::dec_result_t res_o
);
  import etud_pkg::*;

  logic [7:0]  b;
  logic [4:0]  hex;
  logic [20:0] acc_utf;
  logic [15:0] acc_hex;
  logic [20:0] pair_cp;
  logic        emit;
  logic        err;
  logic        esc;
  logic [20:0] cp;
  dec_state_t  nxt;

  assign b       = req_i.text_byte;
  assign hex     = hex_digit(b);
  assign acc_utf = {cur_i.partial[14:0], b[5:0]};
  assign acc_hex = {cur_i.partial[11:0], hex[3:0]};
  assign pair_cp = 21'h10000 + {1'b0, cur_i.high_surr, acc_hex[9:0]};

  always_comb begin
    nxt  = cur_i;
    emit = 1'b0;
    err  = 1'b0;
    esc  = 1'b0;
    cp   = '0;
    case (cur_i.phase)
      PH_IDLE: begin
        if (b == ChBslash && esc_en_i) begin
          nxt.phase = PH_ESC;
        end else if (!b[7]) begin
          emit = 1'b1;
          cp   = {13'd0, b};
        end else if (b inside {[8'hC2:8'hDF]}) begin
          nxt.partial   = {16'd0, b[4:0]};
          nxt.remaining = 3'd1;
          nxt.phase     = PH_U2;
        end else if (b inside {[8'hE0:8'hEF]}) begin
          nxt.partial   = {17'd0, b[3:0]};
          nxt.remaining = 3'd2;
          nxt.phase     = PH_U3;
        end else if (b inside {[8'hF0:8'hF4]}) begin
          nxt.partial   = {18'd0, b[2:0]};
          nxt.remaining = 3'd3;
          nxt.phase     = PH_U4;
        end else begin
          err = 1'b1;
        end
      end
      PH_U2, PH_U3, PH_U4: begin
        if (b[7:6] != 2'b10 || cur_i.remaining == 3'd0) begin
          err = 1'b1;
        end else begin
          nxt.partial   = acc_utf;
          nxt.remaining = cur_i.remaining - 3'd1;
          if (cur_i.remaining == 3'd1) begin
            if (cur_i.phase == PH_U3 && (acc_utf < 21'h800 ||
                acc_utf inside {[21'hD800:21'hDFFF]})) begin
              err = 1'b1;
            end else if (cur_i.phase == PH_U4 && (acc_utf < 21'h10000 ||
                         acc_utf > MaxCodePoint)) begin
              err = 1'b1;
            end else begin
              emit = 1'b1;
              cp   = acc_utf;
            end
          end
        end
      end
      PH_ESC: begin
        esc = 1'b1;
        case (b)
          ChQuote, ChBslash, ChSlash: begin emit = 1'b1; cp = {13'd0, b}; end
          ChB: begin emit = 1'b1; cp = 21'h08; end
          ChF: begin emit = 1'b1; cp = 21'h0C; end
          ChN: begin emit = 1'b1; cp = 21'h0A; end
          ChR: begin emit = 1'b1; cp = 21'h0D; end
          ChT: begin emit = 1'b1; cp = 21'h09; end
          ChU: begin
            nxt.partial   = '0;
            nxt.remaining = 3'd4;
            nxt.phase     = PH_HEX;
          end
          default: err = 1'b1;
        endcase
      end
      PH_HEX, PH_PAIR_HEX: begin
        if (!hex[4] || cur_i.remaining == 3'd0) begin
          err = 1'b1;
        end else begin
          nxt.partial   = {5'd0, acc_hex};
          nxt.remaining = cur_i.remaining - 3'd1;
          if (cur_i.remaining == 3'd1) begin
            if (cur_i.phase == PH_HEX) begin
              if (acc_hex inside {[16'hD800:16'hDBFF]}) begin
                nxt.high_surr = acc_hex[9:0];
                nxt.partial   = '0;
                nxt.phase     = PH_PAIR_BS;
              end else if (acc_hex inside {[16'hDC00:16'hDFFF]}) begin
                err = 1'b1;
              end else begin
                emit = 1'b1;
                esc  = 1'b1;
                cp   = {5'd0, acc_hex};
              end
            end else if (acc_hex inside {[16'hDC00:16'hDFFF]}) begin
              emit = 1'b1;
              esc  = 1'b1;
              cp   = pair_cp;
            end else begin
              err = 1'b1;
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (b == ChBslash) begin
          nxt.phase = PH_PAIR_U;
        end else begin
          err = 1'b1;
        end
      end
      PH_PAIR_U: begin
        if (b == ChU) begin
          nxt.partial   = '0;
          nxt.remaining = 3'd4;
          nxt.phase     = PH_PAIR_HEX;
        end else begin
          err = 1'b1;
        end
      end
      default: nxt = IdleState;
    endcase

    if (emit || err) begin
      nxt = IdleState;
    end
    // text ends inside a sequence
    if (req_i.final_byte && nxt.phase != PH_IDLE) begin
      nxt = IdleState;
      err = 1'b1;
    end
  end

  assign nxt_o                  = nxt;
  assign res_o.valid            = emit || err;
  assign res_o.req.code_point   = err ? 21'd0 : cp;
  assign res_o.req.was_escaped  = esc && !err;
  assign res_o.req.non_ascii    = !err && (cp >= 21'h80);
  assign res_o.req.decode_error = err;

endmodule

// File: hw/rtl/escaped_utf8_text_decoder_core.sv
// A byte's result reaches out_req_o via the input register, decode logic, result register.
// One byte per cycle unless a held result meets out_stall_i, which stalls the input.
// Error-free bytes ending no character (lead, continuation, escape) give no result.
// Reset (async, active low) clears the decode state to idle, escapes off, no valid data.
// Top level of the escaped UTF-8 text decoder.
`include "escaped_utf8_text_decoder_core_defines.svh"

module escaped_utf8_text_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  etud_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output etud_pkg::out_req_t out_req_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);
  import etud_pkg::*;

  logic        in_valid_q;
  in_req_t     in_req_q;
  logic        esc_en_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  dec_result_t res;
  logic        out_valid_q;
  out_req_t    out_req_q;
  logic        advance;
  logic        in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  etud_decode u_decode (
    .cur_i    (state_q),
    .req_i    (in_req_q),
    .esc_en_i (esc_en_q),
    .nxt_o    (state_d),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      esc_en_q    <= 1'b0;
      state_q     <= IdleState;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        esc_en_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= res.valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
    if (advance && res.valid) begin
      out_req_q <= res.req;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  `ETUD_ASSERT_ALWAYS(a_err_clean,
    out_valid_o && out_req_o.decode_error |-> out_req_o.code_point == 21'd0 &&
    !out_req_o.was_escaped && !out_req_o.non_ascii,
    "error result carries data")
  `ETUD_ASSERT(a_cp_legal,
    out_valid_o && !out_req_o.decode_error |-> out_req_o.code_point <= MaxCodePoint &&
    (out_req_o.code_point < 21'hD800 || out_req_o.code_point > 21'hDFFF),
    "code point out of range")
  `ETUD_ASSERT(a_non_ascii,
    out_valid_o && !out_req_o.decode_error |->
    out_req_o.non_ascii == (out_req_o.code_point >= 21'h80),
    "non_ascii flag mismatch")
  `ETUD_ASSERT(a_idle_after, advance && res.valid |=> state_q.phase == PH_IDLE,
    "decoder not idle after result")
  `ETUD_ASSERT(a_state_hold, !advance |=> state_q == $past(state_q),
    "decode state moved without a byte")

endmodule
